@@ rtl/core/vmb_pkg.sv @@
// ----------------------------------------------------------------------------
// vmb_pkg
// Shared types and constants of the virtio-mmio block register file.
// ----------------------------------------------------------------------------
package vmb_pkg;

   localparam int CFG_WIN_BYTES = 64;
   localparam logic [11:0] CFG_BASE = 12'h100;
   localparam logic [11:0] CFG_END  = 12'(int'(CFG_BASE) + CFG_WIN_BYTES);

   localparam logic [31:0] MAGIC_WORD         = 32'h7472_6976;
   localparam logic [31:0] VERSION_MODERN     = 32'd2;
   localparam logic [31:0] BLOCK_DEVICE_ID    = 32'd2;
   localparam logic [31:0] VENDOR_WORD        = 32'h0;
   localparam logic [31:0] STATUS_NEEDS_RESET = 32'd64;
   localparam logic [31:0] ZERO_WORD          = 32'd0;
   localparam logic [31:0] SEL_LOW            = 32'd0;
   localparam logic [31:0] SEL_HIGH           = 32'd1;
   localparam logic [3:0]  REG_LEN            = 4'd4;

   localparam logic [1:0] FLAG_RING   = 2'b01;
   localparam logic [1:0] FLAG_CONFIG = 2'b10;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // register offsets
   localparam logic [11:0] OFF_MAGIC      = 12'h000;
   localparam logic [11:0] OFF_VERSION    = 12'h004;
   localparam logic [11:0] OFF_DEVICE_ID  = 12'h008;
   localparam logic [11:0] OFF_VENDOR     = 12'h00C;
   localparam logic [11:0] OFF_DEV_FEAT   = 12'h010;
   localparam logic [11:0] OFF_DEV_FSEL   = 12'h014;
   localparam logic [11:0] OFF_DRV_FEAT   = 12'h020;
   localparam logic [11:0] OFF_DRV_FSEL   = 12'h024;
   localparam logic [11:0] OFF_QUEUE_SEL  = 12'h030;
   localparam logic [11:0] OFF_QUEUE_MAX  = 12'h034;
   localparam logic [11:0] OFF_QUEUE_SIZE = 12'h038;
   localparam logic [11:0] OFF_QUEUE_RDY  = 12'h044;
   localparam logic [11:0] OFF_NOTIFY     = 12'h050;
   localparam logic [11:0] OFF_IRQ_STATUS = 12'h060;
   localparam logic [11:0] OFF_IRQ_ACK    = 12'h064;
   localparam logic [11:0] OFF_STATUS     = 12'h070;
   localparam logic [11:0] OFF_DESC_LO    = 12'h080;
   localparam logic [11:0] OFF_DESC_HI    = 12'h084;
   localparam logic [11:0] OFF_AVAIL_LO   = 12'h090;
   localparam logic [11:0] OFF_AVAIL_HI   = 12'h094;
   localparam logic [11:0] OFF_USED_LO    = 12'h0A0;
   localparam logic [11:0] OFF_USED_HI    = 12'h0A4;
   localparam logic [11:0] OFF_CFG_GEN    = 12'h0FC;

   // configuration register indexes
   localparam logic [1:0] CSR_FEAT_LO   = 2'd0;
   localparam logic [1:0] CSR_FEAT_HI   = 2'd1;
   localparam logic [1:0] CSR_QUEUE_MAX = 2'd2;
   localparam logic [1:0] CSR_CAPACITY  = 2'd3;

   localparam logic [31:0] RST_FEAT_LO   = 32'h200;
   localparam logic [31:0] RST_FEAT_HI   = 32'h1;
   localparam logic [15:0] RST_QUEUE_MAX = 16'd1024;
   localparam logic [47:0] RST_CAPACITY  = 48'd0;

   typedef struct packed {
      logic        action;
      logic [11:0] offset;
      logic [3:0]  access_len;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        irq_assert;
      logic        irq_deassert;
      logic        queue_kick;
   } rsp_type;

   typedef struct packed {
      logic [31:0] features_low;
      logic [31:0] features_high;
      logic [15:0] ring_limit;
      logic [47:0] capacity_sectors;
   } cfg_type;

endpackage

@@ rtl/core/virtio_mmio_block_register_file.sv @@
// ----------------------------------------------------------------------------
// virtio_mmio_block_register_file
// virtio-mmio v2 transport register file of a block device.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/ready    action, offset, access_len, write_data
//  rsp      out        rsp_valid/ready    read_data, irq_assert, irq_deassert,
//                                         queue_kick
//  csr      in         csr_we             csr_index, csr_wdata
//
//  One access per cycle sustained while rsp_ready is high. The req is taken into
//  the input register, then decode and state update fill the rsp result register.
//  Synchronous reset restores csr defaults and clears transport
//  state. A stalled rsp holds the result; one more request is still taken
//  into the input register before req_ready drops.
// ----------------------------------------------------------------------------
module virtio_mmio_block_register_file (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [11:0] req_offset,
   input  logic [3:0]  req_access_len,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_data,
   output logic        rsp_irq_assert,
   output logic        rsp_irq_deassert,
   output logic        rsp_queue_kick,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   import vmb_pkg::*;

   logic    in_valid_ff,  in_valid_in;
   req_type in_req_ff,    in_req_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff,   out_rsp_in;
   logic    advance;
   cfg_type cfg;
   rsp_type core_rsp;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_req_in    = in_req_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_req_in   = '{action: req_action, offset: req_offset,
                         access_len: req_access_len, write_data: req_write_data};
      end
      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   vmb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vmb_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_rsp_ff.read_data;
   assign rsp_irq_assert   = out_rsp_ff.irq_assert;
   assign rsp_irq_deassert = out_rsp_ff.irq_deassert;
   assign rsp_queue_kick   = out_rsp_ff.queue_kick;

endmodule

@@ rtl/core/vmb_csr.sv @@
// ----------------------------------------------------------------------------
// vmb_csr
// Host-side configuration registers: offered features, queue limit, capacity.
// ----------------------------------------------------------------------------
module vmb_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [47:0]     csr_wdata,
   output vmb_pkg::cfg_type cfg
);
   import vmb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FEAT_LO:   cfg_in.features_low     = csr_wdata[31:0];
            CSR_FEAT_HI:   cfg_in.features_high    = csr_wdata[31:0];
            CSR_QUEUE_MAX: cfg_in.ring_limit       = csr_wdata[15:0];
            CSR_CAPACITY:  cfg_in.capacity_sectors = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.features_low     <= RST_FEAT_LO;
         cfg_ff.features_high    <= RST_FEAT_HI;
         cfg_ff.ring_limit       <= RST_QUEUE_MAX;
         cfg_ff.capacity_sectors <= RST_CAPACITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/vmb_core.sv @@
// ----------------------------------------------------------------------------
// vmb_core
// Transport state and access decode; updates state on each transfer.
// ----------------------------------------------------------------------------
module vmb_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  vmb_pkg::req_type req,
   input  vmb_pkg::cfg_type cfg,
   output vmb_pkg::rsp_type rsp
);
   import vmb_pkg::*;

   logic [31:0] device_status_ff,  device_status_in;
   logic [31:0] dev_fsel_ff,       dev_fsel_in;
   logic [31:0] drv_fsel_ff,       drv_fsel_in;
   logic [31:0] qsel_ff,           qsel_in;
   logic [1:0]  irq_flags_ff,      irq_flags_in;
   logic [31:0] accepted_lo_ff,    accepted_lo_in;
   logic [31:0] accepted_hi_ff,    accepted_hi_in;
   logic [31:0] qrdy_ff,           qrdy_in;
   logic [15:0] qsize_ff,          qsize_in;
   logic [63:0] desc_addr_ff,      desc_addr_in;
   logic [63:0] avail_addr_ff,     avail_addr_in;
   logic [63:0] used_addr_ff,      used_addr_in;

   logic        is_wr;
   logic        in_window;
   logic [11:0] win_base;
   logic [3:0]  win_bytes;
   logic [63:0] win_shifted;
   logic [63:0] win_mask;
   logic        fault_hit;

   assign is_wr     = (req.action == ACT_WRITE);
   assign in_window = (req.offset >= CFG_BASE) && (req.offset < CFG_END);
   assign win_base  = req.offset - CFG_BASE;
   assign win_bytes = (req.access_len > 4'd8) ? 4'd8 : req.access_len;
   assign win_shifted = {16'd0, cfg.capacity_sectors} >> {win_base[2:0], 3'b000};
   assign win_mask  = (win_bytes == 4'd8) ? {64{1'b1}}
                                         : ((64'd1 << {win_bytes[2:0], 3'b000}) - 64'd1);

   always_comb begin
      device_status_in = device_status_ff;
      dev_fsel_in      = dev_fsel_ff;
      drv_fsel_in      = drv_fsel_ff;
      qsel_in          = qsel_ff;
      irq_flags_in     = irq_flags_ff;
      accepted_lo_in   = accepted_lo_ff;
      accepted_hi_in   = accepted_hi_ff;
      qrdy_in          = qrdy_ff;
      qsize_in         = qsize_ff;
      desc_addr_in     = desc_addr_ff;
      avail_addr_in    = avail_addr_ff;
      used_addr_in     = used_addr_ff;
      rsp              = '0;
      fault_hit        = 1'b0;

      if (in_window) begin
         if (!is_wr && (win_base < 12'd8)) begin
            rsp.read_data = win_shifted & win_mask;
         end
      end else if (req.access_len == REG_LEN) begin
         case (req.offset)
            OFF_MAGIC:     if (!is_wr) rsp.read_data = {32'd0, MAGIC_WORD};
            OFF_VERSION:   if (!is_wr) rsp.read_data = {32'd0, VERSION_MODERN};
            OFF_DEVICE_ID: if (!is_wr) rsp.read_data = {32'd0, BLOCK_DEVICE_ID};
            OFF_VENDOR:    if (!is_wr) rsp.read_data = {32'd0, VENDOR_WORD};
            OFF_CFG_GEN:   if (!is_wr) rsp.read_data = {32'd0, ZERO_WORD};
            OFF_DEV_FEAT: begin
               if (!is_wr) begin
                  if (dev_fsel_ff == SEL_LOW) begin
                     rsp.read_data = {32'd0, cfg.features_low};
                  end else if (dev_fsel_ff == SEL_HIGH) begin
                     rsp.read_data = {32'd0, cfg.features_high};
                  end
               end
            end
            OFF_DEV_FSEL:  if (is_wr) dev_fsel_in = req.write_data;
            OFF_DRV_FEAT: begin
               if (is_wr) begin
                  if (drv_fsel_ff == SEL_LOW) begin
                     accepted_lo_in = req.write_data;
                  end else if (drv_fsel_ff == SEL_HIGH) begin
                     accepted_hi_in = req.write_data;
                     fault_hit      = ~req.write_data[0];
                  end
               end
            end
            OFF_DRV_FSEL:  if (is_wr) drv_fsel_in = req.write_data;
            OFF_QUEUE_SEL: if (is_wr) qsel_in = req.write_data;
            OFF_QUEUE_MAX: begin
               if (!is_wr && (qsel_ff == ZERO_WORD)) begin
                  rsp.read_data = {48'd0, cfg.ring_limit};
               end
            end
            OFF_QUEUE_SIZE: begin
               if (is_wr && (qsel_ff == ZERO_WORD)) begin
                  if (req.write_data > {16'd0, cfg.ring_limit}) begin
                     fault_hit = 1'b1;
                  end else begin
                     qsize_in = req.write_data[15:0];
                  end
               end
            end
            OFF_QUEUE_RDY: begin
               if (is_wr) qrdy_in       = req.write_data;
               else       rsp.read_data = {32'd0, qrdy_ff};
            end
            OFF_NOTIFY: begin
               if (is_wr) begin
                  irq_flags_in     = irq_flags_ff | FLAG_RING;
                  rsp.irq_assert   = 1'b1;
                  rsp.queue_kick   = 1'b1;
               end
            end
            OFF_IRQ_STATUS: if (!is_wr) rsp.read_data = {62'd0, irq_flags_ff};
            OFF_IRQ_ACK: begin
               if (is_wr) begin
                  irq_flags_in     = irq_flags_ff & ~req.write_data[1:0];
                  rsp.irq_deassert = 1'b1;
               end
            end
            OFF_STATUS: begin
               if (!is_wr) begin
                  rsp.read_data = {32'd0, device_status_ff};
               end else if (req.write_data == ZERO_WORD) begin
                  device_status_in = '0;
                  dev_fsel_in      = '0;
                  drv_fsel_in      = '0;
                  qsel_in          = '0;
                  irq_flags_in     = '0;
                  accepted_lo_in   = '0;
                  accepted_hi_in   = '0;
                  qrdy_in          = '0;
                  qsize_in         = '0;
                  desc_addr_in     = '0;
                  avail_addr_in    = '0;
                  used_addr_in     = '0;
               end else begin
                  device_status_in = req.write_data;
               end
            end
            OFF_DESC_LO:  if (is_wr) desc_addr_in[31:0]   = req.write_data;
            OFF_DESC_HI:  if (is_wr) desc_addr_in[63:32]  = req.write_data;
            OFF_AVAIL_LO: if (is_wr) avail_addr_in[31:0]  = req.write_data;
            OFF_AVAIL_HI: if (is_wr) avail_addr_in[63:32] = req.write_data;
            OFF_USED_LO:  if (is_wr) used_addr_in[31:0]   = req.write_data;
            OFF_USED_HI:  if (is_wr) used_addr_in[63:32]  = req.write_data;
            default: ;
         endcase
         if (fault_hit) begin
            device_status_in = STATUS_NEEDS_RESET;
            irq_flags_in     = FLAG_CONFIG;
            rsp.irq_assert   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_status_ff <= '0;
         dev_fsel_ff      <= '0;
         drv_fsel_ff      <= '0;
         qsel_ff          <= '0;
         irq_flags_ff     <= '0;
         accepted_lo_ff   <= '0;
         accepted_hi_ff   <= '0;
         qrdy_ff          <= '0;
         qsize_ff         <= '0;
         desc_addr_ff     <= '0;
         avail_addr_ff    <= '0;
         used_addr_ff     <= '0;
      end else if (fire) begin
         device_status_ff <= device_status_in;
         dev_fsel_ff      <= dev_fsel_in;
         drv_fsel_ff      <= drv_fsel_in;
         qsel_ff          <= qsel_in;
         irq_flags_ff     <= irq_flags_in;
         accepted_lo_ff   <= accepted_lo_in;
         accepted_hi_ff   <= accepted_hi_in;
         qrdy_ff          <= qrdy_in;
         qsize_ff         <= qsize_in;
         desc_addr_ff     <= desc_addr_in;
         avail_addr_ff    <= avail_addr_in;
         used_addr_ff     <= used_addr_in;
      end
   end

   kick_raises_irq: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.queue_kick |-> rsp.irq_assert)
      else $error("queue kick without interrupt raise");

   irq_dir_excl: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(rsp.irq_assert && rsp.irq_deassert))
      else $error("interrupt raised and lowered by one access");

   write_reads_zero: assert property (@(posedge clock) disable iff (reset)
      fire && is_wr |-> rsp.read_data == 64'd0)
      else $error("write access returned read data");

   status_clear: assert property (@(posedge clock) disable iff (reset)
      fire && is_wr && !in_window && req.access_len == REG_LEN
         && req.offset == OFF_STATUS && req.write_data == ZERO_WORD
      |=> device_status_ff == ZERO_WORD && irq_flags_ff == 2'b00
         && qsize_ff == 16'd0)
      else $error("status write of zero did not clear transport state");

   fault_recorded: assert property (@(posedge clock) disable iff (reset)
      fire && fault_hit |=> device_status_ff == STATUS_NEEDS_RESET
         && irq_flags_ff == FLAG_CONFIG)
      else $error("needs-reset not recorded");

endmodule
